@@ hw/rtl/oahm_pkg.sv @@
// oahm_pkg: shared widths, codes and controller/datapath interface types
// for the open addressing hash map core; no dependencies
package oahm_pkg;

    // default slot count (power of two)
    localparam int SLOTS_DEF = 16;

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 64;
    localparam int ST_W    = 3;
    localparam int SLOT_W  = 4;
    localparam int PROBE_W = 5;

    // operation codes; code three decodes as write by its high bit
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd2;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_FOUND = 3'd0,
        ST_NEW   = 3'd1,
        ST_FULL  = 3'd2,
        ST_ZERO  = 3'd3,
        ST_LIMIT = 3'd4
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic clear;   // write one empty key during the clearing pass
        logic start;   // request accepted, capture fields
        logic check;   // compare the fetched slot and act on it
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last; // last slot of the clearing pass
        logic early;    // request resolves without probing
        logic finish;   // probe walk ends this cycle
    } t_sts;

endpackage

@@ hw/rtl/oahm_ctrl.sv @@
// oahm_ctrl: sequencing state machine of the hash map core
// depends on oahm_pkg for the command and status types
module oahm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output oahm_pkg::t_cmd  o_cmd,
    input  oahm_pkg::t_sts  i_sts
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_CHECK = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register, clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.start = 1'b1;
                    if (!i_sts.early) n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state = i_sts.finish ? S_IDLE : S_READ;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ hw/rtl/oahm_dpath.sv @@
// oahm_dpath: key and value stores, probe registers and result registers
// depends on oahm_pkg for widths, codes and the command and status types
module oahm_dpath #(
    parameter int SLOTS = oahm_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  oahm_pkg::t_cmd                 i_cmd,
    output oahm_pkg::t_sts                 o_sts,
    input  logic [oahm_pkg::OP_W-1:0]      i_op,
    input  logic [oahm_pkg::KEY_W-1:0]     i_key,
    input  logic [oahm_pkg::VAL_W-1:0]     i_value,
    output logic                           o_valid,
    output logic [oahm_pkg::VAL_W-1:0]     o_read_value,
    output logic [oahm_pkg::ST_W-1:0]      o_status,
    output logic [oahm_pkg::SLOT_W-1:0]    o_slot,
    output logic [oahm_pkg::PROBE_W-1:0]   o_probes_used,
    output logic [oahm_pkg::PROBE_W-1:0]   o_max_probes
);

    localparam int PW   = $clog2(SLOTS);
    localparam int CW   = PW + 1;
    localparam int HALF = SLOTS / 2;
    localparam int SW   = oahm_pkg::SLOT_W;
    localparam int NW   = oahm_pkg::PROBE_W;

    // stores
    logic [oahm_pkg::KEY_W-1:0] key_mem [SLOTS];
    logic [oahm_pkg::VAL_W-1:0] val_mem [SLOTS];
    logic [oahm_pkg::KEY_W-1:0] r_key_rd;
    logic [oahm_pkg::VAL_W-1:0] r_val_rd;

    // request and probe registers
    logic [oahm_pkg::OP_W-1:0]  r_op;
    logic [oahm_pkg::KEY_W-1:0] r_key;
    logic [oahm_pkg::VAL_W-1:0] r_value;
    logic [PW-1:0]              r_pos;
    logic [CW-1:0]              r_n;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_worst, n_worst;
    logic [PW-1:0]              r_clr;

    // result registers
    logic                       r_valid, n_valid;
    logic [oahm_pkg::VAL_W-1:0] r_res_val, n_res_val;
    oahm_pkg::t_status          r_res_st, n_res_st;
    logic [PW-1:0]              r_res_pos, n_res_pos;
    logic [CW-1:0]              r_res_n, n_res_n;

    // store write port
    logic                       key_we, val_we;
    logic [PW-1:0]              wr_addr;
    logic [oahm_pkg::KEY_W-1:0] key_wd;
    logic [oahm_pkg::VAL_W-1:0] val_wd;

    logic is_ins, hit, empty, limit, full_r, full_in, zero_in;
    logic [oahm_pkg::VAL_W-1:0] new_val;

    // width adaption of results to the fixed output fields
    logic [PW+SW-1:0] pos_ext;
    logic [CW+NW-1:0] n_ext, worst_ext;

    // slot decode of the fetched entry
    assign is_ins  = (r_op == oahm_pkg::OP_INSERT);
    assign hit     = !is_ins && (r_key_rd == r_key);
    assign empty   = (r_key_rd == '0);
    assign limit   = (r_n == CW'(SLOTS));
    assign full_r  = (r_count >= CW'(HALF));
    assign full_in = (i_op == oahm_pkg::OP_INSERT) && full_r;
    assign zero_in = (i_key == '0);
    assign new_val = (r_op == oahm_pkg::OP_READ) ? '0 : r_value;

    assign o_sts.clr_last = (r_clr == {PW{1'b1}});
    assign o_sts.early    = zero_in || full_in;
    assign o_sts.finish   = hit || empty || limit;

    // probe decision, store updates and next result
    always_comb begin
        key_we    = 1'b0;
        val_we    = 1'b0;
        wr_addr   = r_pos;
        key_wd    = r_key;
        val_wd    = new_val;
        n_count   = r_count;
        n_worst   = r_worst;
        n_valid   = 1'b0;
        n_res_val = r_res_val;
        n_res_st  = r_res_st;
        n_res_pos = r_res_pos;
        n_res_n   = r_res_n;
        if (i_cmd.clear) begin
            key_we  = 1'b1;
            wr_addr = r_clr;
            key_wd  = '0;
        end else if (i_cmd.start && o_sts.early) begin
            n_valid   = 1'b1;
            n_res_val = '0;
            n_res_st  = zero_in ? oahm_pkg::ST_ZERO : oahm_pkg::ST_FULL;
            n_res_pos = '0;
            n_res_n   = '0;
        end else if (i_cmd.check && o_sts.finish) begin
            n_valid = 1'b1;
            n_res_n = r_n;
            if (hit) begin
                // existing key, write replaces the value
                val_we    = r_op[1];
                val_wd    = r_value;
                n_res_val = r_op[1] ? r_value : r_val_rd;
                n_res_st  = oahm_pkg::ST_FOUND;
                n_res_pos = r_pos;
            end else if (empty && !is_ins && full_r) begin
                n_res_val = '0;
                n_res_st  = oahm_pkg::ST_FULL;
                n_res_pos = '0;
            end else if (empty) begin
                // place a new entry
                key_we    = 1'b1;
                val_we    = 1'b1;
                n_count   = r_count + 1'b1;
                if (is_ins && (r_n > r_worst)) n_worst = r_n;
                n_res_val = new_val;
                n_res_st  = oahm_pkg::ST_NEW;
                n_res_pos = r_pos;
            end else begin
                n_res_val = '0;
                n_res_st  = oahm_pkg::ST_LIMIT;
                n_res_pos = '0;
            end
        end
    end

    // stores: one write port, registered read at the probe position
    always_ff @(posedge i_clk) begin
        if (key_we) key_mem[wr_addr] <= key_wd;
        if (val_we) val_mem[wr_addr] <= val_wd;
        r_key_rd <= key_mem[r_pos];
        r_val_rd <= val_mem[r_pos];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_count <= '0;
            r_worst <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) r_clr <= r_clr + 1'b1;
            r_count <= n_count;
            r_worst <= n_worst;
            r_valid <= n_valid;
        end
    end

    // request capture and probe stepping
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= i_value;
            r_pos   <= i_key[PW-1:0];
            r_n     <= CW'(1);
        end else if (i_cmd.check && !o_sts.finish) begin
            r_pos <= r_pos + r_n[PW-1:0];
            r_n   <= r_n + 1'b1;
        end
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
        r_res_pos <= n_res_pos;
        r_res_n   <= n_res_n;
    end

    // outputs
    assign pos_ext   = {{SW{1'b0}}, r_res_pos};
    assign n_ext     = {{NW{1'b0}}, r_res_n};
    assign worst_ext = {{NW{1'b0}}, r_worst};

    assign o_valid       = r_valid;
    assign o_read_value  = r_res_val;
    assign o_status      = r_res_st;
    assign o_slot        = pos_ext[SW-1:0];
    assign o_probes_used = n_ext[NW-1:0];
    assign o_max_probes  = worst_ext[NW-1:0];

endmodule

@@ hw/rtl/open_addressing_hash_map_core.sv @@
// a zero key or refused insert gives its result the cycle after start; otherwise
// each probe is a store read then a compare; the result follows the last compare
// a new request is taken only once the previous one is done, while busy is low
// reset: a clearing pass empties the key store slot by slot, busy high meanwhile
// results strobe on o_valid for one cycle; the receiver cannot stall
// depends on oahm_pkg, oahm_ctrl and oahm_dpath
module open_addressing_hash_map_core #(
    parameter int SLOTS = oahm_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [oahm_pkg::OP_W-1:0]      i_op,
    input  logic [oahm_pkg::KEY_W-1:0]     i_key,
    input  logic [oahm_pkg::VAL_W-1:0]     i_value,
    output logic                           o_valid,
    output logic [oahm_pkg::VAL_W-1:0]     o_read_value,
    output logic [oahm_pkg::ST_W-1:0]      o_status,
    output logic [oahm_pkg::SLOT_W-1:0]    o_slot,
    output logic [oahm_pkg::PROBE_W-1:0]   o_probes_used,
    output logic [oahm_pkg::PROBE_W-1:0]   o_max_probes
);

    oahm_pkg::t_cmd cmd;
    oahm_pkg::t_sts sts;

    // sequencer
    oahm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // stores and result registers
    oahm_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_probes_used (o_probes_used),
        .o_max_probes  (o_max_probes)
    );

endmodule

@@ test/open_addressing_hash_map_core_test.sv @@
// open_addressing_hash_map_core_test: self-checking regression for the hash map core
// sends requests over the start/busy handshake and checks each strobed result
// against a table model held here; depends on oahm_pkg and open_addressing_hash_map_core
module open_addressing_hash_map_core_test;

    localparam int TABLE_SLOTS = oahm_pkg::SLOTS_DEF;
    localparam int OP_BITS     = oahm_pkg::OP_W;
    localparam int PROBE_BITS  = oahm_pkg::PROBE_W;
    // op code three acts as write, decoded by its high bit
    localparam logic [oahm_pkg::OP_W-1:0] OP_WRITE_HI = 2'd3;
    localparam int RANDOM_REQUESTS = 1700;

    typedef struct {
        logic [oahm_pkg::VAL_W-1:0]   read_value;
        oahm_pkg::t_status            status;
        logic [oahm_pkg::SLOT_W-1:0]  slot;
        logic [oahm_pkg::PROBE_W-1:0] probes_used;
        logic [oahm_pkg::PROBE_W-1:0] max_probes;
    } t_map_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [oahm_pkg::OP_W-1:0]      i_op;
    logic [oahm_pkg::KEY_W-1:0]     i_key;
    logic [oahm_pkg::VAL_W-1:0]     i_value;
    logic                           o_valid;
    logic [oahm_pkg::VAL_W-1:0]     o_read_value;
    logic [oahm_pkg::ST_W-1:0]      o_status;
    logic [oahm_pkg::SLOT_W-1:0]    o_slot;
    logic [oahm_pkg::PROBE_W-1:0]   o_probes_used;
    logic [oahm_pkg::PROBE_W-1:0]   o_max_probes;

    // table model state
    logic [oahm_pkg::KEY_W-1:0]   table_keys [TABLE_SLOTS] = '{default: '0};
    logic [oahm_pkg::VAL_W-1:0]   table_values [TABLE_SLOTS] = '{default: '0};
    int unsigned                  table_fill = 0;
    logic [oahm_pkg::PROBE_W-1:0] worst_walk = '0;

    t_map_result pending_results [$];
    int          mismatches = 0;
    int          requests_sent = 0;
    int          status_tally [5] = '{default: 0};
    bit          gaps_on = 1'b1;

    open_addressing_hash_map_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_probes_used (o_probes_used),
        .o_max_probes  (o_max_probes)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("open_addressing_hash_map_core regression: fail");
        $finish;
    end

    // applies one request to the table model and returns the result it gives
    function automatic t_map_result apply_to_table(input logic [oahm_pkg::OP_W-1:0] op,
                                                   input logic [oahm_pkg::KEY_W-1:0] key,
                                                   input logic [oahm_pkg::VAL_W-1:0] value);
        t_map_result                  r;
        logic [oahm_pkg::SLOT_W-1:0]  pos;
        logic [oahm_pkg::PROBE_W-1:0] n;
        logic                         pair_insert;
        logic                         hit_empty;
        r.read_value  = '0;
        r.status      = oahm_pkg::ST_ZERO;
        r.slot        = '0;
        r.probes_used = '0;
        r.max_probes  = worst_walk;
        pair_insert   = (op == oahm_pkg::OP_INSERT);
        if (key == '0)
            return r;
        // insert refused before any probe
        if (pair_insert && table_fill + 1 > TABLE_SLOTS / 2) begin
            r.status = oahm_pkg::ST_FULL;
            return r;
        end
        // triangular walk: home, +1, +2, +3 ...
        pos       = key[oahm_pkg::SLOT_W-1:0];
        n         = PROBE_BITS'(1);
        hit_empty = 1'b0;
        while (!hit_empty) begin
            if (!pair_insert && table_keys[pos] == key) begin
                if (op[1])
                    table_values[pos] = value;
                r.read_value  = table_values[pos];
                r.status      = oahm_pkg::ST_FOUND;
                r.slot        = pos;
                r.probes_used = n;
                return r;
            end
            if (table_keys[pos] == '0) begin
                hit_empty = 1'b1;
            end else if (n >= TABLE_SLOTS) begin
                r.status      = oahm_pkg::ST_LIMIT;
                r.probes_used = n;
                return r;
            end else begin
                pos = pos + n[oahm_pkg::SLOT_W-1:0];
                n   = n + 1'b1;
            end
        end
        // create refused only once the key is known to be absent
        if (!pair_insert && table_fill + 1 > TABLE_SLOTS / 2) begin
            r.status      = oahm_pkg::ST_FULL;
            r.probes_used = n;
            return r;
        end
        table_keys[pos]   = key;
        table_values[pos] = (op == oahm_pkg::OP_READ) ? '0 : value;
        table_fill++;
        if (pair_insert && n > worst_walk)
            worst_walk = n;
        r.read_value  = table_values[pos];
        r.status      = oahm_pkg::ST_NEW;
        r.slot        = pos;
        r.probes_used = n;
        r.max_probes  = worst_walk;
        return r;
    endfunction

    // send one request, with an occasional gap before it, and log its result
    task automatic issue_request(input logic [oahm_pkg::OP_W-1:0] op,
                                 input logic [oahm_pkg::KEY_W-1:0] key,
                                 input logic [oahm_pkg::VAL_W-1:0] value);
        if (gaps_on && $urandom_range(99) < 14) begin
            start <= 1'b0;
            repeat ($urandom_range(($urandom_range(3) == 0) ? 40 : 3, 1)) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        i_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(apply_to_table(op, key, value));
        requests_sent++;
    endtask

    // hold until every logged result has come back
    task automatic wait_for_results();
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // zero key is rejected for every op code
    task automatic test_zero_key();
        issue_request(oahm_pkg::OP_INSERT, '0, '1);
        issue_request(oahm_pkg::OP_READ, '0, '0);
        issue_request(oahm_pkg::OP_WRITE, '0, 64'hAAAA_AAAA_AAAA_AAAA);
        issue_request(OP_WRITE_HI, '0, 64'h5555_5555_5555_5555);
    endtask

    // inserts, duplicates, found and create paths, long walks from home slot 0
    task automatic test_create_paths();
        issue_request(oahm_pkg::OP_INSERT, 32'h0000_0010, '1);
        issue_request(oahm_pkg::OP_INSERT, 32'h0000_0010, '0);
        issue_request(oahm_pkg::OP_READ, 32'h0000_0010, 64'h0123_4567_89AB_CDEF);
        issue_request(oahm_pkg::OP_WRITE, 32'h0000_0010, 64'h5555_5555_5555_5555);
        issue_request(OP_WRITE_HI, 32'h0000_0010, 64'hAAAA_AAAA_AAAA_AAAA);
        issue_request(oahm_pkg::OP_READ, 32'hFFFF_FFF0, '1);
        issue_request(oahm_pkg::OP_WRITE, 32'hFFFF_FFFF, 64'hFEDC_BA98_7654_3210);
        issue_request(OP_WRITE_HI, 32'h8000_0001, '1);
        issue_request(oahm_pkg::OP_READ, 32'h0000_0020, '1);
        issue_request(oahm_pkg::OP_INSERT, 32'h0000_0030, 64'h8000_0000_0000_0001);
        issue_request(oahm_pkg::OP_INSERT, 32'h0000_0040, '0);
    endtask

    // table at half load: insert refused up front, creates refused after walking
    task automatic test_table_full();
        issue_request(oahm_pkg::OP_INSERT, 32'h0000_0050, '1);
        issue_request(oahm_pkg::OP_READ, 32'h0000_0060, '1);
        issue_request(oahm_pkg::OP_WRITE, 32'h0000_0070, '1);
        issue_request(OP_WRITE_HI, 32'hFFFF_FF00, '1);
        issue_request(oahm_pkg::OP_READ, 32'h0000_0040, '1);
        issue_request(oahm_pkg::OP_INSERT, '0, '1);
    endtask

    // random mix of hits, misses, refused inserts and zero keys
    task automatic test_random_traffic();
        logic [oahm_pkg::OP_W-1:0]  op;
        logic [oahm_pkg::KEY_W-1:0] key;
        logic [oahm_pkg::VAL_W-1:0] value;
        int                         pick;
        int                         slot_idx;
        bit                         clash;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            gaps_on = !(n >= 700 && n < 1000);
            // hold the sender off until the core has drained
            if (n % 500 == 499) begin
                start <= 1'b0;
                wait_for_results();
            end
            case ($urandom_range(7))
                0:       value = '0;
                1:       value = '1;
                default: value = {$urandom(), $urandom()};
            endcase
            pick = $urandom_range(99);
            if (pick < 5) begin
                key = '0;
                op  = OP_BITS'($urandom_range(3));
            end else if (pick < 15) begin
                key = $urandom();
                op  = oahm_pkg::OP_INSERT;
            end else if (pick < 60 && table_fill != 0) begin
                do slot_idx = $urandom_range(TABLE_SLOTS - 1);
                while (table_keys[slot_idx] == '0);
                key = table_keys[slot_idx];
                op  = OP_BITS'($urandom_range(3, 1));
            end else begin
                do begin
                    key   = $urandom();
                    clash = (key == '0);
                    for (int s = 0; s < TABLE_SLOTS; s++)
                        if (table_keys[s] == key)
                            clash = 1'b1;
                end while (clash);
                op = OP_BITS'($urandom_range(3));
            end
            issue_request(op, key, value);
        end
    endtask

    // result checker: each strobe against the oldest logged result
    always @(posedge i_clk) begin
        t_map_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: status %0d slot %0d",
                       o_status, o_slot);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                status_tally[want.status]++;
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %h, got %h", want.read_value, o_read_value);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, o_slot);
                    mismatches++;
                end
                if (o_probes_used !== want.probes_used) begin
                    $error("probes_used: expected %0d, got %0d", want.probes_used,
                           o_probes_used);
                    mismatches++;
                end
                if (o_max_probes !== want.max_probes) begin
                    $error("max_probes: expected %0d, got %0d", want.max_probes,
                           o_max_probes);
                    mismatches++;
                end
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_op    <= '0;
        i_key   <= '0;
        i_value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_key();
        test_create_paths();
        test_table_full();
        test_random_traffic();

        start <= 1'b0;
        wait_for_results();
        repeat (40) @(posedge i_clk);

        $display("sent %0d requests: %0d hits, %0d created, %0d refused full, %0d zero keys",
                 requests_sent, status_tally[oahm_pkg::ST_FOUND],
                 status_tally[oahm_pkg::ST_NEW], status_tally[oahm_pkg::ST_FULL],
                 status_tally[oahm_pkg::ST_ZERO]);
        $display("table ended with %0d keys, longest insert walk %0d probes",
                 table_fill, worst_walk);
        if (mismatches == 0)
            $display("open_addressing_hash_map_core regression: pass");
        else
            $display("open_addressing_hash_map_core regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/oahm_pkg.sv
hw/rtl/oahm_ctrl.sv
hw/rtl/oahm_dpath.sv
hw/rtl/open_addressing_hash_map_core.sv
test/open_addressing_hash_map_core_test.sv
